[src/eyelid_pkg.sv]
package eyelid_pkg;

    localparam int DISPLAY_SIZE_DEF = 240;

    localparam logic [2:0] REG_MODE_FLAGS   = 3'd0;
    localparam logic [2:0] REG_EYELID_COLOR = 3'd1;
    localparam logic [2:0] REG_EYE_RADIUS   = 3'd2;
    localparam logic [2:0] REG_CENTER_X     = 3'd3;
    localparam logic [2:0] REG_CENTER_Y     = 3'd4;
    localparam logic [2:0] REG_UPPER_ROW    = 3'd5;
    localparam logic [2:0] REG_LOWER_ROW    = 3'd6;
    localparam logic [2:0] REG_GAP_CLOSED   = 3'd7;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TABLE = 1'b1;

    // configuration seen by the datapath
    typedef struct packed {
        logic        custom;
        logic        swap;
        logic [15:0] color;
        logic [7:0]  radius;
        logic signed [9:0]  cx;
        logic signed [9:0]  cy;
        logic signed [10:0] upper_row;
        logic signed [10:0] lower_row;
        logic [8:0]  gap;
    } eyelid_cfg_t;

    // entry of the edge memory
    typedef struct packed {
        logic [7:0] upper_inner;
        logic [7:0] lower_outer;
        logic [7:0] lower_inner;
    } eyelid_entry_t;

endpackage

[src/eyelid_cfg_regs.sv]
module eyelid_cfg_regs
    import eyelid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output eyelid_cfg_t cfg
);

    eyelid_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.custom    <= 1'b0;
            cfg_reg.swap      <= 1'b0;
            cfg_reg.color     <= '0;
            cfg_reg.radius    <= '0;
            cfg_reg.cx        <= 10'sd120;
            cfg_reg.cy        <= 10'sd120;
            cfg_reg.upper_row <= 11'sd0;
            cfg_reg.lower_row <= 11'sd239;
            cfg_reg.gap       <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE_FLAGS: begin
                    cfg_reg.custom <= cfg_data[0];
                    cfg_reg.swap   <= cfg_data[1];
                end
                REG_EYELID_COLOR: cfg_reg.color     <= cfg_data;
                REG_EYE_RADIUS:   cfg_reg.radius    <= cfg_data[7:0];
                REG_CENTER_X:     cfg_reg.cx        <= cfg_data[9:0];
                REG_CENTER_Y:     cfg_reg.cy        <= cfg_data[9:0];
                REG_UPPER_ROW:    cfg_reg.upper_row <= cfg_data[10:0];
                REG_LOWER_ROW:    cfg_reg.lower_row <= cfg_data[10:0];
                REG_GAP_CLOSED:   cfg_reg.gap       <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

endmodule

[src/eyelid_newton_step.sv]
// One quotient bit of s/d for a Newton step d' = (d + s/d)/2 on 16-bit s, 8-bit d, one stage.
// The quotient is computed by a restoring divider spread over the stage
// chain of the parent; this module does one quotient bit per instance.
module eyelid_newton_step
    import eyelid_pkg::*;
(
    input  logic [16:0] rem_in,
    input  logic [15:0] num_in,
    input  logic [7:0]  div_in,
    input  logic [4:0]  bit_idx,
    output logic [16:0] rem_out,
    output logic        q_bit
);

    logic [16:0] trial;

    // shift in next numerator bit and try to subtract the divisor
    always_comb begin
        trial = {rem_in[15:0], num_in[bit_idx[3:0]]};
        if (trial >= {9'd0, div_in}) begin
            rem_out = trial - {9'd0, div_in};
            q_bit   = 1'b1;
        end else begin
            rem_out = trial;
            q_bit   = 1'b0;
        end
    end

endmodule

[src/eyelid_pixel_pipe.sv]
module eyelid_pixel_pipe
    import eyelid_pkg::*;
#(
    parameter int DISPLAY_SIZE = DISPLAY_SIZE_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  eyelid_cfg_t cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_action,
    input  logic [7:0]  in_x,
    input  logic [7:0]  in_y,
    input  logic [15:0] in_pixel,
    input  logic [7:0]  in_col,
    input  logic [7:0]  in_ui,
    input  logic [7:0]  in_lo,
    input  logic [7:0]  in_li,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_pixel,
    output logic        out_painted
);

    localparam int NSTEP = 3;
    localparam int DBITS = 16;
    // stages: 0 prep, then NSTEP*(DBITS+1) Newton stages, then table, edges, out
    localparam int NS    = NSTEP * (DBITS + 1);
    localparam int IDX_W = (DISPLAY_SIZE > 1) ? $clog2(DISPLAY_SIZE) : 1;

    // per-stage payload; table writes ride along with col and ent
    typedef struct packed {
        logic        pix;
        logic        inframe;
        logic        incircle;
        logic [7:0]  y;
        logic [15:0] pin;
        logic signed [10:0] col;
        logic [15:0] s;
        logic [7:0]  d;
        logic [16:0] rem;
        logic [15:0] q;
        logic        dflt_hit;
        eyelid_entry_t ent;
    } stage_t;

    stage_t st_reg [NS+1];
    logic   vl_reg [NS+1];
    logic   adv;

    // output register
    logic        ov_reg;
    logic [15:0] opix_reg;
    logic        opnt_reg;

    // tail stages after the Newton chain
    logic        t1v_reg, t2v_reg;
    stage_t      t1_reg, t2_reg;
    eyelid_entry_t rd_reg;
    logic [7:0]  dy_t1_reg, dy_t2_reg;
    logic        hit2;

    // whole pipe advances when output slot is free
    assign adv         = !ov_reg || out_ready;
    assign in_ready    = adv;
    assign out_valid   = ov_reg;
    assign out_pixel   = opix_reg;
    assign out_painted = opnt_reg;

    // edge memory
    eyelid_entry_t mem [DISPLAY_SIZE];
    logic        wr_en;
    logic [IDX_W-1:0] rd_addr;

    // floor(b * DISPLAY_SIZE / 255) by shift-add reciprocal, exact below 65281
    function automatic logic [8:0] scale_byte(input logic [7:0] b);
        logic [16:0] p;
        p = 17'(b) * 17'(DISPLAY_SIZE);
        return 9'((p + 17'd1 + (p >> 8)) >> 8);
    endfunction

    // stage 0: geometry prep
    logic signed [10:0] dx0, dy0, col0;
    logic [21:0] dxsq0, rsq0, dysq0;
    stage_t s0;
    always_comb begin
        dx0   = $signed({3'b0, in_x}) - 11'(cfg.cx);
        dy0   = $signed({3'b0, in_y}) - 11'(cfg.cy);
        col0  = dx0 + 11'(DISPLAY_SIZE / 2);
        dxsq0 = $unsigned(22'(dx0) * 22'(dx0));
        dysq0 = $unsigned(22'(dy0) * 22'(dy0));
        rsq0  = 22'(cfg.radius) * 22'(cfg.radius);
        s0          = '0;
        s0.pix      = in_action == ACT_PIXEL;
        s0.inframe  = {1'b0, in_x} < 9'(DISPLAY_SIZE) && {1'b0, in_y} < 9'(DISPLAY_SIZE);
        s0.incircle = dxsq0 <= rsq0;
        s0.y        = in_y;
        s0.pin      = in_pixel;
        s0.col      = (in_action == ACT_TABLE) ? $signed({3'b0, in_col}) : col0;
        s0.s        = s0.incircle ? 16'(rsq0 - dxsq0) : 16'd0;
        s0.d        = cfg.radius;
        s0.dflt_hit = (dxsq0 + dysq0 <= rsq0)
                      && ($signed({3'b0, in_y}) <= cfg.upper_row
                          || $signed({3'b0, in_y}) >= cfg.lower_row);
        s0.ent      = '{in_ui, in_lo, in_li};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vl_reg[0] <= 1'b0;
        else if (adv) vl_reg[0] <= in_valid;
        if (adv) st_reg[0] <= s0;
    end

    // Newton chain: per step, DBITS divider stages then an update stage
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_nt
            localparam int BIT = DBITS - 1 - (g % (DBITS + 1));
            stage_t nx;
            if ((g % (DBITS + 1)) < DBITS) begin : g_div
                logic [16:0] ro;
                logic        qb;
                eyelid_newton_step u_step (
                    .rem_in  ((g % (DBITS + 1)) == 0 ? 17'd0 : st_reg[g].rem),
                    .num_in  (st_reg[g].s),
                    .div_in  (st_reg[g].d),
                    .bit_idx (5'(BIT)),
                    .rem_out (ro),
                    .q_bit   (qb)
                );
                always_comb begin
                    nx     = st_reg[g];
                    nx.rem = ro;
                    nx.q   = {(g % (DBITS + 1)) == 0 ? 15'd0 : st_reg[g].q[14:0], qb};
                end
            end else begin : g_upd
                logic [16:0] sum;
                always_comb begin
                    nx  = st_reg[g];
                    sum = {9'd0, st_reg[g].d} + {1'b0, st_reg[g].q};
                    if (st_reg[g].d != 8'd0) nx.d = 8'(sum >> 1);
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) vl_reg[g+1] <= 1'b0;
                else if (adv) vl_reg[g+1] <= vl_reg[g];
                if (adv) st_reg[g+1] <= nx;
            end
        end
    endgenerate

    // table read; table writes land at this same stage so stream order holds
    assign rd_addr = st_reg[NS].col[IDX_W-1:0];
    assign wr_en   = adv && vl_reg[NS] && !st_reg[NS].pix
                     && st_reg[NS].col < 11'(DISPLAY_SIZE);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1v_reg <= 1'b0;
            t2v_reg <= 1'b0;
        end else if (adv) begin
            t1v_reg <= vl_reg[NS] && st_reg[NS].pix;
            t2v_reg <= t1v_reg;
        end
        if (wr_en) mem[rd_addr] <= st_reg[NS].ent;
        if (adv) begin
            t1_reg    <= st_reg[NS];
            dy_t1_reg <= st_reg[NS].s == 16'd0 ? 8'd0 : st_reg[NS].d;
            rd_reg    <= mem[rd_addr];
            t2_reg    <= t1_reg;
            dy_t2_reg <= dy_t1_reg;
        end
    end

    // scaled edges and products, registered
    logic signed [11:0] top1, bot1, ui1, li1;
    logic signed [21:0] pu1, pl1;
    logic signed [21:0] pu_reg, pl_reg;
    logic signed [11:0] top_reg, bot_reg;
    logic        hu_reg, hl_reg, colok_reg;
    always_comb begin
        top1 = 12'(cfg.cy) - $signed({4'b0, dy_t1_reg});
        bot1 = 12'(cfg.cy) + $signed({4'b0, dy_t1_reg});
        ui1  = $signed({3'b0, scale_byte(rd_reg.upper_inner)});
        li1  = $signed({3'b0, scale_byte(rd_reg.lower_inner)});
        pu1  = 22'(ui1 - top1) * $signed({13'b0, (cfg.gap > 9'd256) ? 9'd256 : cfg.gap});
        pl1  = 22'(bot1 - li1) * $signed({13'b0, (cfg.gap > 9'd256) ? 9'd256 : cfg.gap});
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            pu_reg    <= pu1;
            pl_reg    <= pl1;
            top_reg   <= top1;
            bot_reg   <= bot1;
            hu_reg    <= rd_reg.upper_inner != 8'd0;
            hl_reg    <= rd_reg.lower_outer != 8'd0;
            colok_reg <= t1_reg.col >= 0 && t1_reg.col < 11'(DISPLAY_SIZE);
        end
    end

    // span test
    logic signed [11:0] ue, le, yy;
    logic        ch;
    always_comb begin
        ue = top_reg + 12'(pu_reg / 256);
        le = bot_reg - 12'(pl_reg / 256);
        yy = $signed({4'b0, t2_reg.y});
        ch = t2_reg.incircle && colok_reg
             && ((hu_reg && ue > top_reg && yy >= top_reg && yy < ue)
              || (hl_reg && le < bot_reg && yy >= le && yy < bot_reg));
        hit2 = t2_reg.inframe && (cfg.custom ? ch : t2_reg.dflt_hit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (adv) ov_reg <= t2v_reg;
        if (adv) begin
            opnt_reg <= hit2;
            opix_reg <= hit2 ? (cfg.swap ? {cfg.color[7:0], cfg.color[15:8]} : cfg.color)
                             : t2_reg.pin;
        end
    end

endmodule

[src/eyelid_overlay_pixel_mask.sv]
// Eyelid overlay pixel mask.
// Input channel s_*: one item per cycle, either a pixel (s_action = 0) or an
// edge table column write (s_action = 1). Table writes give no result; they
// travel the pipe and land in the table in stream order with the pixels.
// Result channel m_*: one item per pixel, in order, with the original value
// or the eyelid color and m_painted set.
// Config channel cfg_*: index 0..7 selects the register; always ready.
// Write config only while no pixel is in flight.
// The pipe has 55 register stages from an accepted pixel to m_valid: one
// prep stage, three Newton steps of 17 stages (16
// divider bits plus update), table read, edge product stage and the output
// register. Throughput is one item per cycle; the whole pipe holds when
// m_ready is low with m_valid high, and s_ready drops with it.
// Reset clears the pipe valids and loads register defaults; the edge table
// is not cleared and must be written before custom mode is used.
module eyelid_overlay_pixel_mask
    import eyelid_pkg::*;
#(
    parameter int DISPLAY_SIZE = DISPLAY_SIZE_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_pix_x,
    input  logic [7:0]  s_pix_y,
    input  logic [15:0] s_pixel_in,
    input  logic [7:0]  s_table_col,
    input  logic [7:0]  s_upper_inner_byte,
    input  logic [7:0]  s_lower_outer_byte,
    input  logic [7:0]  s_lower_inner_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_out,
    output logic        m_painted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    eyelid_cfg_t cfg;

    eyelid_cfg_regs u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
    );

    eyelid_pixel_pipe #(.DISPLAY_SIZE(DISPLAY_SIZE)) u_pipe (
        .aclk, .aresetn, .cfg,
        .in_valid (s_valid), .in_ready (s_ready), .in_action (s_action),
        .in_x (s_pix_x), .in_y (s_pix_y), .in_pixel (s_pixel_in),
        .in_col (s_table_col), .in_ui (s_upper_inner_byte),
        .in_lo (s_lower_outer_byte), .in_li (s_lower_inner_byte),
        .out_valid (m_valid), .out_ready (m_ready),
        .out_pixel (m_pixel_out), .out_painted (m_painted)
    );

endmodule

[tb/eyelid_checker.sv]
module eyelid_checker
    import eyelid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_pix_x,
    input  logic [7:0]  s_pix_y,
    input  logic [15:0] s_pixel_in,
    input  logic [7:0]  s_table_col,
    input  logic [7:0]  s_upper_inner_byte,
    input  logic [7:0]  s_lower_outer_byte,
    input  logic [7:0]  s_lower_inner_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_pixel_out,
    input  logic        m_painted,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int DSIZE = DISPLAY_SIZE_DEF;

    typedef struct packed {
        logic [15:0] pixel;
        logic        painted;
    } pix_result_t;

    pix_result_t pixel_queue[$];

    // shadow configuration
    logic [1:0]         sh_mode;
    logic [15:0]        sh_color;
    logic [7:0]         sh_radius;
    logic signed [9:0]  sh_cx;
    logic signed [9:0]  sh_cy;
    logic signed [10:0] sh_upper;
    logic signed [10:0] sh_lower;
    logic [8:0]         sh_gap;
    eyelid_entry_t      edge_mem[DSIZE];

    function automatic int scale_edge(logic [7:0] b);
        return (int'(b) * DSIZE) / 255;
    endfunction

    function automatic bit custom_paint(int x, int y);
        int r, rsq, dx, dxsq, dymax, col, top, bot, g, inner, edge_row;
        int unsigned s, d;
        bit hit;
        r = sh_radius;
        rsq = r * r;
        dx = x - int'(sh_cx);
        dxsq = dx * dx;
        dymax = 0;
        hit = 0;
        g = (sh_gap > 256) ? 256 : sh_gap;
        if (dxsq > rsq) return 0;
        if (rsq - dxsq > 0) begin
            s = rsq - dxsq;
            d = r;
            for (int i = 0; i < 3; i++)
                if (d != 0) d = (d + s / d) / 2;
            dymax = d;
        end
        top = int'(sh_cy) - dymax;
        bot = int'(sh_cy) + dymax;
        col = x - int'(sh_cx) + DSIZE / 2;
        if (col < 0 || col >= DSIZE) return 0;
        if (edge_mem[col].upper_inner != 0) begin
            inner = scale_edge(edge_mem[col].upper_inner);
            edge_row = top + ((inner - top) * g) / 256;
            if (edge_row > top && y >= top && y < edge_row) hit = 1;
        end
        if (edge_mem[col].lower_outer != 0) begin
            inner = scale_edge(edge_mem[col].lower_inner);
            edge_row = bot - ((bot - inner) * g) / 256;
            if (edge_row < bot && y >= edge_row && y < bot) hit = 1;
        end
        return hit;
    endfunction

    function automatic pix_result_t overlay_pixel(int x, int y, logic [15:0] pin);
        pix_result_t res;
        bit hit;
        int dx, dy;
        hit = 0;
        if (x < DSIZE && y < DSIZE) begin
            if (sh_mode[0]) begin
                hit = custom_paint(x, y);
            end else begin
                dx = x - int'(sh_cx);
                dy = y - int'(sh_cy);
                if (y <= int'(sh_upper) || y >= int'(sh_lower))
                    hit = (dx * dx + dy * dy) <= int'(sh_radius) * int'(sh_radius);
            end
        end
        if (hit) begin
            res.pixel = sh_mode[1] ? {sh_color[7:0], sh_color[15:8]} : sh_color;
            res.painted = 1'b1;
        end else begin
            res.pixel = pin;
            res.painted = 1'b0;
        end
        return res;
    endfunction

    assign pending_count = pixel_queue.size();

    always @(posedge aclk) begin
        pix_result_t want;
        if (!aresetn) begin
            sh_mode <= 2'd0;
            sh_color <= 16'd0;
            sh_radius <= 8'd0;
            sh_cx <= 10'sd120;
            sh_cy <= 10'sd120;
            sh_upper <= 11'sd0;
            sh_lower <= 11'sd239;
            sh_gap <= 9'd0;
            fail_count <= 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE_FLAGS:   sh_mode <= cfg_data[1:0];
                    REG_EYELID_COLOR: sh_color <= cfg_data;
                    REG_EYE_RADIUS:   sh_radius <= cfg_data[7:0];
                    REG_CENTER_X:     sh_cx <= cfg_data[9:0];
                    REG_CENTER_Y:     sh_cy <= cfg_data[9:0];
                    REG_UPPER_ROW:    sh_upper <= cfg_data[10:0];
                    REG_LOWER_ROW:    sh_lower <= cfg_data[10:0];
                    REG_GAP_CLOSED:   sh_gap <= cfg_data[8:0];
                    default: ;
                endcase
            end
            // accepted inputs
            if (s_valid && s_ready) begin
                if (s_action == ACT_TABLE) begin
                    if (s_table_col < DSIZE)
                        edge_mem[s_table_col] <= '{s_upper_inner_byte,
                            s_lower_outer_byte, s_lower_inner_byte};
                end else begin
                    pixel_queue.push_back(overlay_pixel(s_pix_x, s_pix_y, s_pixel_in));
                end
            end
            // accepted results
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h/%b",
                        m_pixel_out, m_painted);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want.pixel !== m_pixel_out || want.painted !== m_painted) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h/%b got %h/%b",
                                want.pixel, want.painted, m_pixel_out, m_painted);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/tb.sv]
module tb;
    import eyelid_pkg::*;

    localparam int LATENCY = 55;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = ACT_PIXEL;
    logic [7:0]  s_pix_x = '0;
    logic [7:0]  s_pix_y = '0;
    logic [15:0] s_pixel_in = '0;
    logic [7:0]  s_table_col = '0;
    logic [7:0]  s_upper_inner_byte = '0;
    logic [7:0]  s_lower_outer_byte = '0;
    logic [7:0]  s_lower_inner_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_pixel_out;
    logic        m_painted;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_MODE_FLAGS;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int send_idle_pct = 38;
    int recv_idle_pct = 49;

    always #5 aclk = ~aclk;

    eyelid_overlay_pixel_mask u_dut (.*);
    eyelid_checker u_chk (.*);

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // drop the input, then wait until every expected result has come
    task automatic wait_empty();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        wait_empty();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // valid stays high after the accept; the next call replaces the item or drops it, and wait_empty drops it
    task automatic send_item(logic act, logic [7:0] x, logic [7:0] y, logic [15:0] pin,
                             logic [7:0] col, logic [7:0] ui, logic [7:0] lo,
                             logic [7:0] li);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_pix_x <= x;
        s_pix_y <= y;
        s_pixel_in <= pin;
        s_table_col <= col;
        s_upper_inner_byte <= ui;
        s_lower_outer_byte <= lo;
        s_lower_inner_byte <= li;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pixel(logic [7:0] x, logic [7:0] y);
        send_item(ACT_PIXEL, x, y, 16'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    // wait for all results, then let the pipe drain
    task automatic drain_pipe();
        wait_empty();
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // program a random eye near the frame
    task automatic random_setup(bit custom);
        write_reg(REG_MODE_FLAGS, 16'({1'($urandom_range(1)), custom}));
        write_reg(REG_EYELID_COLOR, 16'($urandom));
        write_reg(REG_EYE_RADIUS, 16'($urandom_range(255)));
        write_reg(REG_CENTER_X, 16'($signed($urandom_range(400)) - 80));
        write_reg(REG_CENTER_Y, 16'($signed($urandom_range(400)) - 80));
        write_reg(REG_UPPER_ROW, 16'($signed($urandom_range(400)) - 100));
        write_reg(REG_LOWER_ROW, 16'($signed($urandom_range(400)) - 100));
        write_reg(REG_GAP_CLOSED, $urandom_range(3) == 0 ? 16'($urandom_range(511))
                                                        : 16'($urandom_range(256)));
    endtask

    // fill every table column so custom reads are defined
    task automatic fill_tables();
        for (int c = 0; c < DISPLAY_SIZE_DEF; c++)
            send_item(ACT_TABLE, 8'($urandom), 8'($urandom), 16'($urandom), c[7:0],
                      8'($urandom), $urandom_range(3) == 0 ? 8'd0 : 8'($urandom),
                      8'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default mode extremes
        write_reg(REG_EYELID_COLOR, 16'h12F0);
        write_reg(REG_EYE_RADIUS, 16'd255);
        write_reg(REG_UPPER_ROW, 16'd100);
        write_reg(REG_LOWER_ROW, 16'd140);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd120, 8'd120);
        send_pixel(8'd120, 8'd50);
        send_pixel(8'd239, 8'd239);
        send_pixel(8'd255, 8'd10);
        send_pixel(8'd10, 8'd240);
        write_reg(REG_MODE_FLAGS, 16'd2);
        send_pixel(8'd120, 8'd200);
        // out-of-frame table write is ignored
        send_item(ACT_TABLE, 8'd0, 8'd0, 16'd0, 8'd250, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_TABLE, 8'd0, 8'd0, 16'd0, 8'd255, 8'h00, 8'h00, 8'h00);
        fill_tables();
        send_pixel(8'd0, 8'd0);
        drain_pipe();

        // directed: custom mode, closed and saturated gap, signed extremes
        write_reg(REG_MODE_FLAGS, 16'd3);
        write_reg(REG_GAP_CLOSED, 16'd256);
        write_reg(REG_CENTER_X, 16'h0200);
        write_reg(REG_CENTER_Y, 16'h01FF);
        write_reg(REG_UPPER_ROW, 16'h0400);
        write_reg(REG_LOWER_ROW, 16'h03FF);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd200, 8'd200);
        write_reg(REG_CENTER_X, 16'd120);
        write_reg(REG_CENTER_Y, 16'd120);
        write_reg(REG_EYE_RADIUS, 16'd100);
        write_reg(REG_GAP_CLOSED, 16'd511);
        send_pixel(8'd120, 8'd25);
        send_pixel(8'd120, 8'd215);
        send_pixel(8'd20, 8'd120);
        write_reg(REG_GAP_CLOSED, 16'd0);
        send_pixel(8'd120, 8'd120);
        write_reg(REG_EYE_RADIUS, 16'd0);
        send_pixel(8'd120, 8'd120);
        drain_pipe();

        // random phases: idle profiles swap, then none
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                send_idle_pct = 49;
                recv_idle_pct = 38;
            end else if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup(ph[0]);
            if (ph == 6) fill_tables();
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(9) == 0)
                    send_pixel(8'($urandom), 8'($urandom));
                else
                    send_pixel(8'($urandom_range(239)), 8'($urandom_range(239)));
                if (i == 40) wait_empty();
            end
            drain_pipe();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
